@@ sv/tsam_pkg.sv @@
package tsam_pkg;

	// default node capacity and register reset
	localparam int NODES_DEF = 8;
	localparam logic [3:0] NODE_COUNT_RST = 4'd5;

	// field widths
	localparam int ROW_W = 8;
	localparam int NODE_W = 3;
	localparam int COUNT_W = 4;
	localparam int INDEX_W = 3;

	// command codes
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_RUN = 1'b1;

	// result status codes
	localparam logic STAT_OK = 1'b0;
	localparam logic STAT_CYCLE = 1'b1;

endpackage

@@ sv/tsam_ram.sv @@
module tsam_ram #(
	parameter int WIDTH = 3,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// single write port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ sv/tsam_pick.sv @@
module tsam_pick #(
	parameter int NODES = tsam_pkg::NODES_DEF,
	localparam int IW = $clog2(NODES)
) (
	input  logic [tsam_pkg::ROW_W-1:0] rows [NODES],
	input  logic [NODES-1:0]           unplaced,
	output logic                       found,
	output logic [IW-1:0]              idx
);

	logic [tsam_pkg::ROW_W-1:0] blocked;
	logic [NODES-1:0]           cand;

	// columns hit by any unplaced source row
	always_comb begin
		blocked = '0;
		for (int s = 0; s < NODES; s++) begin
			if (unplaced[s]) begin
				blocked = blocked | rows[s];
			end
		end
	end

	// free nodes: unplaced and not blocked; nodes past the row width are never blocked
	always_comb begin
		for (int k = 0; k < NODES; k++) begin
			if (k < tsam_pkg::ROW_W) begin
				cand[k] = unplaced[k] & ~blocked[k % tsam_pkg::ROW_W];
			end else begin
				cand[k] = unplaced[k];
			end
		end
	end

	// lowest-numbered free node
	always_comb begin
		idx = '0;
		for (int k = NODES - 1; k >= 0; k--) begin
			if (cand[k]) begin
				idx = IW'(k);
			end
		end
	end

	assign found = |cand;

endmodule

@@ sv/topological_sort_adjacency_matrix.sv @@
// Kahn topological sort over an adjacency matrix held in flip-flops. A beat with func
// = load writes one outgoing-edge row; a beat with func = run places one node per
// cycle through a shared pick unit (OR of the unplaced rows and a lowest-free priority
// encoder) until all n nodes are placed or a cycle stops it early. A sorted run then
// emits its n results, each read from the order RAM in S_EMIT_RD (registered read)
// and loaded into the output register in S_EMIT_WR; a cycle verdict is one result.
// in_stall stays high from the run beat until the last result has entered the output
// register. The user writes node_count over cfg_valid/cfg_ready only while the block
// is idle; the block itself does not enforce this. node_count is clamped to 1..NODES.
module topological_sort_adjacency_matrix #(
	parameter int NODES = tsam_pkg::NODES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// config write
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tsam_pkg::COUNT_W-1:0]    node_count,
	// input channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            func,
	input  logic [tsam_pkg::INDEX_W-1:0]    row_index,
	input  logic [tsam_pkg::ROW_W-1:0]      row_bits,
	// output channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [tsam_pkg::NODE_W-1:0]     node,
	output logic                            status,
	output logic                            last
);

	localparam int IW = $clog2(NODES);
	localparam int NW = $clog2(NODES + 1);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_SORT    = 3'd1;
	localparam logic [2:0] S_EMIT_RD = 3'd2;
	localparam logic [2:0] S_EMIT_WR = 3'd3;
	localparam logic [2:0] S_CYC     = 3'd4;

	logic [2:0]                       state_q;
	logic [tsam_pkg::COUNT_W-1:0]     nc_q;
	logic [tsam_pkg::ROW_W-1:0]       rows_q [NODES];
	logic [NODES-1:0]                 mask_q;
	logic [NW-1:0]                    cnt_q;
	logic [NW-1:0]                    idx_q;
	logic                             out_valid_q;
	logic [tsam_pkg::NODE_W-1:0]      node_q;
	logic                             status_q;
	logic                             last_q;

	logic [NW-1:0]                    n;
	logic [NODES-1:0]                 act;
	logic [NODES-1:0]                 unplaced;
	logic                             pick_found;
	logic [IW-1:0]                    pick_idx;
	logic [NW-1:0]                    cnt_nxt;
	logic [NW-1:0]                    idx_nxt;
	logic                             out_free;
	logic                             out_load;
	logic                             ram_we;
	logic [tsam_pkg::NODE_W-1:0]      ram_rdata;

	// node count in use, clamped to 1..NODES
	always_comb begin
		if (nc_q == '0) begin
			n = NW'(1);
		end else if (int'(nc_q) > NODES) begin
			n = NW'(NODES);
		end else begin
			n = NW'(nc_q);
		end
	end

	// nodes below the count that are still unplaced
	always_comb begin
		for (int s = 0; s < NODES; s++) begin
			act[s] = (NW'(s) < n);
		end
	end
	assign unplaced = act & ~mask_q;

	tsam_pick #(
		.NODES(NODES)
	) u_pick (
		.rows     (rows_q),
		.unplaced (unplaced),
		.found    (pick_found),
		.idx      (pick_idx)
	);

	// order store, written while placing, read while emitting
	assign ram_we = (state_q == S_SORT) && pick_found;

	tsam_ram #(
		.WIDTH(tsam_pkg::NODE_W),
		.DEPTH(NODES)
	) u_order (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_q[IW-1:0]),
		.wdata (tsam_pkg::NODE_W'(pick_idx)),
		.raddr (idx_q[IW-1:0]),
		.rdata (ram_rdata)
	);

	assign cnt_nxt  = cnt_q + 1'b1;
	assign idx_nxt  = idx_q + 1'b1;
	assign out_free = !out_valid_q || !out_stall;
	assign out_load = out_free && (state_q == S_EMIT_WR || state_q == S_CYC);

	// sequencer, graph store and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			nc_q        <= tsam_pkg::NODE_COUNT_RST;
			mask_q      <= '0;
			cnt_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			node_q      <= '0;
			status_q    <= tsam_pkg::STAT_OK;
			last_q      <= 1'b0;
			for (int r = 0; r < NODES; r++) begin
				rows_q[r] <= '0;
			end
		end else begin
			if (cfg_valid) begin
				nc_q <= node_count;
			end
			// output valid: set by a new result, cleared when the held beat leaves
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (func == tsam_pkg::FUNC_RUN) begin
							mask_q  <= '0;
							cnt_q   <= '0;
							state_q <= S_SORT;
						end else if (int'(row_index) < NODES) begin
							rows_q[IW'(row_index)] <= row_bits;
						end
					end
				end
				S_SORT: begin
					if (pick_found) begin
						mask_q[pick_idx] <= 1'b1;
						cnt_q            <= cnt_nxt;
						if (cnt_nxt == n) begin
							idx_q   <= '0;
							state_q <= S_EMIT_RD;
						end
					end else begin
						state_q <= S_CYC;
					end
				end
				S_EMIT_RD: begin
					state_q <= S_EMIT_WR;
				end
				S_EMIT_WR: begin
					if (out_free) begin
						node_q      <= ram_rdata;
						status_q    <= tsam_pkg::STAT_OK;
						last_q      <= (idx_nxt == n);
						if (idx_nxt == n) begin
							state_q <= S_IDLE;
						end else begin
							idx_q   <= idx_nxt;
							state_q <= S_EMIT_RD;
						end
					end
				end
				S_CYC: begin
					if (out_free) begin
						node_q      <= '0;
						status_q    <= tsam_pkg::STAT_CYCLE;
						last_q      <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign node      = node_q;
	assign status    = status_q;
	assign last      = last_q;

	// a cycle verdict is a single, final beat with node zero
	a_cycle_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == tsam_pkg::STAT_CYCLE |-> node == '0 && last)
		else $error("cycle result malformed");

	// placing never runs past the node count
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SORT |-> cnt_q < n)
		else $error("placed count past node count");

	// emission starts only with every active node placed
	a_all_placed: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT_RD && $past(state_q) == S_SORT |-> (mask_q == act && cnt_q == n))
		else $error("emission with unplaced nodes");

	// input is held off for the whole run
	a_run_holds: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && func == tsam_pkg::FUNC_RUN |=> in_stall)
		else $error("input accepted during run");

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps

// one result beat: node, status, last
typedef struct packed {
	logic [tsam_pkg::NODE_W-1:0] node;
	logic                        status;
	logic                        last;
} order_beat_t;

// Kahn order predictor plus the queue of node beats still owed by the block
class kahn_order_book;
	logic [tsam_pkg::ROW_W-1:0]   adj_rows[tsam_pkg::NODES_DEF];
	logic [tsam_pkg::COUNT_W-1:0] count_reg;
	order_beat_t                  order_due[$];
	int                           errors;

	function new();
		foreach (adj_rows[i]) adj_rows[i] = '0;
		count_reg = tsam_pkg::NODE_COUNT_RST;
		errors = 0;
	endfunction

	function void set_count(logic [tsam_pkg::COUNT_W-1:0] v);
		count_reg = v;
	endfunction

	function int pending();
		return order_due.size();
	endfunction

	// accepted input beat: a load updates a row, a run predicts the whole order
	function void note_beat(logic f, logic [tsam_pkg::INDEX_W-1:0] r,
			logic [tsam_pkg::ROW_W-1:0] b);
		order_beat_t                    ob;
		logic [tsam_pkg::NODES_DEF-1:0] placed;
		logic [tsam_pkg::NODE_W-1:0]    seq[tsam_pkg::NODES_DEF];
		int                             n, got, rnd, j, s, pick;
		bit                             found, blocked, stuck;
		if (f == tsam_pkg::FUNC_LOAD) begin
			adj_rows[r] = b;
			return;
		end
		n = (count_reg == 0) ? 1 :
			((count_reg > tsam_pkg::NODES_DEF) ? tsam_pkg::NODES_DEF : count_reg);
		placed = '0;
		got = 0;
		stuck = 0;
		pick = 0;
		for (rnd = 0; rnd < n && !stuck; rnd++) begin
			found = 0;
			for (j = 0; j < n && !found; j++) begin
				if (!placed[j]) begin
					// any unplaced source with an edge into j blocks it, self-loop too
					blocked = 0;
					for (s = 0; s < n; s++)
						if (!placed[s] && adj_rows[s][j]) blocked = 1;
					if (!blocked) begin
						found = 1;
						pick = j;
					end
				end
			end
			if (!found) begin
				stuck = 1;
			end else begin
				seq[got] = tsam_pkg::NODE_W'(pick);
				placed[pick] = 1'b1;
				got++;
			end
		end
		if (got != n) begin
			ob.node = '0;
			ob.status = tsam_pkg::STAT_CYCLE;
			ob.last = 1'b1;
			order_due.push_back(ob);
		end else begin
			for (j = 0; j < n; j++) begin
				ob.node = seq[j];
				ob.status = tsam_pkg::STAT_OK;
				ob.last = (j == n - 1);
				order_due.push_back(ob);
			end
		end
	endfunction

	// accepted output beat against the oldest expectation
	function void check_beat(logic [tsam_pkg::NODE_W-1:0] nd, logic st, logic lst);
		order_beat_t ob;
		if (order_due.size() == 0) begin
			if (errors < 10)
				$display("%0t: unexpected beat node=%0d status=%0d last=%0d",
					$time, nd, st, lst);
			errors++;
			return;
		end
		ob = order_due.pop_front();
		if (nd !== ob.node || st !== ob.status || lst !== ob.last) begin
			if (errors < 10)
				$display({"%0t: order mismatch exp node=%0d status=%0d last=%0d,",
					" got node=%0d status=%0d last=%0d"},
					$time, ob.node, ob.status, ob.last, nd, st, lst);
			errors++;
		end
	endfunction
endclass

module tb_top;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [tsam_pkg::COUNT_W-1:0]  node_count;
	logic                          in_valid;
	logic                          in_stall;
	logic                          func;
	logic [tsam_pkg::INDEX_W-1:0]  row_index;
	logic [tsam_pkg::ROW_W-1:0]    row_bits;
	logic                          out_valid;
	logic                          out_stall;
	logic [tsam_pkg::NODE_W-1:0]   node;
	logic                          status;
	logic                          last;

	kahn_order_book book;
	int  beats_sent = 0;
	int  active_n = 5;
	bit  burst = 0;

	topological_sort_adjacency_matrix dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.node_count (node_count),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.row_index  (row_index),
		.row_bits   (row_bits),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.node       (node),
		.status     (status),
		.last       (last)
	);

	always #6 clk = ~clk;

	// mostly back to back, some short gaps, a few long ones
	function automatic int pick_gap();
		int p;
		if (burst) return 0;
		p = $urandom_range(0, 99);
		if (p < 65) return 0;
		if (p < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// one input beat; valid stays up if the next beat follows with no gap
	task automatic send_beat(input logic f, input logic [tsam_pkg::INDEX_W-1:0] r,
			input logic [tsam_pkg::ROW_W-1:0] b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		row_index <= r;
		row_bits <= b;
		do @(posedge clk); while (in_stall);
		book.note_beat(f, r, b);
		beats_sent++;
	endtask

	// stop sending and wait for every owed result, plus slack for a trailing load
	task automatic hold_off();
		in_valid <= 1'b0;
		while (book.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// node_count write, only with the block idle
	task automatic write_node_count(input logic [tsam_pkg::COUNT_W-1:0] v);
		hold_off();
		cfg_valid <= 1'b1;
		node_count <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		book.set_count(v);
		active_n = (v == 0) ? 1 :
			((v > tsam_pkg::NODES_DEF) ? tsam_pkg::NODES_DEF : v);
	endtask

	// random DAG on the active nodes, optionally broken by a back edge or self-loop
	task automatic sort_graph(input bit add_cycle);
		int                         perm[tsam_pkg::NODES_DEF];
		logic [tsam_pkg::ROW_W-1:0] rows[tsam_pkg::NODES_DEF];
		logic [tsam_pkg::ROW_W-1:0] used;
		int                         i, j, k, tmp, dens, n;
		n = active_n;
		used = tsam_pkg::ROW_W'((1 << n) - 1);
		for (i = 0; i < tsam_pkg::NODES_DEF; i++) perm[i] = i;
		for (i = n - 1; i > 0; i--) begin
			k = $urandom_range(0, i);
			tmp = perm[i];
			perm[i] = perm[k];
			perm[k] = tmp;
		end
		// junk edges toward unused nodes, full junk in unused rows
		for (i = 0; i < tsam_pkg::NODES_DEF; i++)
			rows[i] = (i < n) ? (tsam_pkg::ROW_W'($urandom) & ~used)
				: tsam_pkg::ROW_W'($urandom);
		dens = $urandom_range(0, 100);
		for (i = 0; i < n; i++)
			for (j = i + 1; j < n; j++)
				if ($urandom_range(0, 99) < dens) rows[perm[i]][perm[j]] = 1'b1;
		if (add_cycle) begin
			if (n == 1 || $urandom_range(0, 2) == 0) begin
				k = $urandom_range(0, n - 1);
				rows[k][k] = 1'b1;
			end else begin
				i = $urandom_range(0, n - 2);
				j = $urandom_range(i + 1, n - 1);
				rows[perm[j]][perm[i]] = 1'b1;
			end
		end
		for (i = 0; i < tsam_pkg::NODES_DEF; i++)
			if (i < n || $urandom_range(0, 2) != 0)
				send_beat(tsam_pkg::FUNC_LOAD, tsam_pkg::INDEX_W'(i), rows[i]);
		send_beat(tsam_pkg::FUNC_RUN, tsam_pkg::INDEX_W'($urandom),
			tsam_pkg::ROW_W'($urandom));
	endtask

	// a few fully random loads, then a run, sometimes two runs
	task automatic noise_run();
		int i;
		for (i = $urandom_range(0, 4); i > 0; i--)
			send_beat(tsam_pkg::FUNC_LOAD, tsam_pkg::INDEX_W'($urandom),
				tsam_pkg::ROW_W'($urandom));
		send_beat(tsam_pkg::FUNC_RUN, tsam_pkg::INDEX_W'($urandom),
			tsam_pkg::ROW_W'($urandom));
		if ($urandom_range(0, 2) == 0)
			send_beat(tsam_pkg::FUNC_RUN, tsam_pkg::INDEX_W'($urandom),
				tsam_pkg::ROW_W'($urandom));
	endtask

	// output side: check accepted beats, stall in random stretches
	initial begin
		int stall_left, seg_left, p;
		bit calm;
		stall_left = 0;
		seg_left = 0;
		calm = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) book.check_beat(node, status, last);
			if (seg_left == 0) begin
				calm = ($urandom_range(0, 3) == 0);
				seg_left = $urandom_range(50, 300);
			end
			seg_left--;
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (calm) begin
				out_stall <= 1'b0;
			end else begin
				p = $urandom_range(0, 99);
				if (p < 75) begin
					out_stall <= 1'b0;
				end else begin
					stall_left = (p < 95) ? $urandom_range(0, 2) : $urandom_range(9, 39);
					out_stall <= 1'b1;
				end
			end
		end
	end

	// run limit
	initial begin
		#10_000_000;
		$display("FAIL topological_sort_adjacency_matrix");
		$finish;
	end

	// reset, directed cases, random phases, drain
	initial begin
		logic [tsam_pkg::COUNT_W-1:0] cv;
		int p;
		book = new();
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		node_count <= '0;
		in_valid <= 1'b0;
		func <= tsam_pkg::FUNC_LOAD;
		row_index <= '0;
		row_bits <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// reset count of five, empty graph sorts in index order
		send_beat(tsam_pkg::FUNC_RUN, '0, '0);
		// self-loop on node 0
		send_beat(tsam_pkg::FUNC_LOAD, 3'd0, 8'hFF);
		send_beat(tsam_pkg::FUNC_RUN, 3'd7, 8'hFF);
		// edge 4 -> 0 defers node 0; unused row 7 ignored
		send_beat(tsam_pkg::FUNC_LOAD, 3'd0, 8'h00);
		send_beat(tsam_pkg::FUNC_LOAD, 3'd4, 8'h01);
		send_beat(tsam_pkg::FUNC_LOAD, 3'd7, 8'hFF);
		// edges only past the node count are ignored
		send_beat(tsam_pkg::FUNC_LOAD, 3'd2, 8'hE0);
		send_beat(tsam_pkg::FUNC_RUN, '0, '0);

		// full capacity: row 7 now live with its self-loop
		write_node_count(4'd8);
		send_beat(tsam_pkg::FUNC_RUN, '0, '0);
		send_beat(tsam_pkg::FUNC_LOAD, 3'd7, 8'h01);
		send_beat(tsam_pkg::FUNC_LOAD, 3'd1, 8'h80);
		send_beat(tsam_pkg::FUNC_RUN, '0, '0);
		// two-node cycle 5 <-> 6
		send_beat(tsam_pkg::FUNC_LOAD, 3'd5, 8'h40);
		send_beat(tsam_pkg::FUNC_LOAD, 3'd6, 8'h20);
		send_beat(tsam_pkg::FUNC_RUN, '0, '0);

		// count above capacity saturates
		write_node_count(4'd15);
		send_beat(tsam_pkg::FUNC_RUN, '0, '0);
		// count zero acts as one node
		write_node_count(4'd0);
		send_beat(tsam_pkg::FUNC_LOAD, 3'd0, 8'h01);
		send_beat(tsam_pkg::FUNC_RUN, '0, '0);
		send_beat(tsam_pkg::FUNC_LOAD, 3'd0, 8'hFE);
		send_beat(tsam_pkg::FUNC_RUN, '0, '0);
		write_node_count(4'd1);
		send_beat(tsam_pkg::FUNC_RUN, '0, '0);

		// random phases, each with its own node count
		while (beats_sent < 330) begin
			p = $urandom_range(0, 9);
			case (p)
				0: cv = 4'd0;
				1: cv = 4'd1;
				2: cv = 4'd8;
				3: cv = 4'd15;
				default: cv = tsam_pkg::COUNT_W'($urandom_range(0, 15));
			endcase
			write_node_count(cv);
			repeat ($urandom_range(1, 5)) begin
				if ($urandom_range(0, 6) == 0) hold_off();
				burst = ($urandom_range(0, 3) == 0);
				if ($urandom_range(0, 4) == 0)
					noise_run();
				else
					sort_graph($urandom_range(0, 4) == 0);
			end
		end

		in_valid <= 1'b0;
		while (book.pending() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (book.errors == 0)
			$display("PASS topological_sort_adjacency_matrix");
		else
			$display("FAIL topological_sort_adjacency_matrix");
		$finish;
	end

endmodule
